// ===== src/ppvd_pkg.sv =====
// Package for the planar palette video decoder: payload structs, group
// descriptors and the command-pair decode function.
// Depends on nothing; every other file imports it.
package ppvd_pkg;

    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW = 8;

    localparam logic [7:0] CMD_FOREIGN_MIN = 8'h40;
    localparam logic [7:0] MASK_RESET = 8'hff;
    localparam logic [1:0] BLANK_LINES = 2'd2;

    localparam logic [1:0] COMP_RED = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE = 2'd2;

    typedef enum logic [1:0] {
        OP_POINTER = 2'd0,
        OP_MASK    = 2'd1,
        OP_WRITE   = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        GRP_BLACK  = 2'd0,
        GRP_PIXELS = 2'd1,
        GRP_REJECT = 2'd2
    } grp_kind_t;

    typedef struct packed {
        logic [3:0] sample;
        logic       line_start;
        logic       frame_start;
        logic       audio_enable_bit;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
        logic       frame_rejected;
    } out_word_t;

    typedef struct packed {
        logic             cmd_mode;
        logic [1:0]       blank;
        logic [7:0]       mask;
        logic [PAL_AW-1:0] cptr;
        logic [1:0]       comp;
    } ctl_t;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [1:0]        comp;
        logic [7:0]        data;
    } wr_op_t;

    typedef struct packed {
        grp_kind_t          kind;
        logic [3:0][7:0]    idx;
        wr_op_t [1:0]       wr;
    } grp_t;

    typedef struct packed {
        ctl_t   ctl;
        wr_op_t wr;
        logic   reject;
    } pair_res_t;

    localparam ctl_t CTL_RESET = '{
        cmd_mode: 1'b1,
        blank:    2'd0,
        mask:     MASK_RESET,
        cptr:     '0,
        comp:     COMP_RED
    };

    // Decodes one command/parameter pair against the current control state.
    function automatic pair_res_t run_pair(input logic [7:0] cmd, input logic [7:0] parm,
                                           input ctl_t ctl, input logic auto_det);
        pair_res_t r;
        r = '{ctl: ctl, wr: '0, reject: 1'b0};
        if (auto_det && (cmd >= CMD_FOREIGN_MIN))
        begin
            r.reject = 1'b1;
        end
        else if (cmd[3])
        begin
            r.ctl.cmd_mode = 1'b0;
            r.ctl.blank = BLANK_LINES;
        end
        else if (cmd[2])
        begin
            case (cmd[1:0])
                OP_POINTER:
                begin
                    r.ctl.cptr = parm;
                    r.ctl.comp = COMP_RED;
                end
                OP_MASK:
                begin
                    r.ctl.mask = parm;
                end
                OP_WRITE:
                begin
                    r.wr.en = 1'b1;
                    r.wr.addr = ctl.cptr;
                    r.wr.comp = ctl.comp;
                    r.wr.data = {parm[5:0], parm[1:0]};
                    if (ctl.comp == COMP_BLUE)
                    begin
                        r.ctl.comp = COMP_RED;
                        r.ctl.cptr = ctl.cptr + 1'b1;
                    end
                    else
                    begin
                        r.ctl.comp = ctl.comp + 1'b1;
                    end
                end
                OP_NOP:
                begin
                    r.reject = 1'b0;
                end
                default:
                begin
                    r.reject = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

endpackage

// ===== src/ppvd_front.sv =====
// Front end: gathers samples into plane bytes, tracks frame and line state,
// decodes command groups and hands one descriptor per group to the queue.
// Depends on ppvd_pkg.
module ppvd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  ppvd_pkg::in_word_t in_data,
    input  logic             auto_detect,
    output logic             push,
    output ppvd_pkg::grp_t   grp
);
    import ppvd_pkg::*;

    ctl_t            ctl_reg, ctl_next;
    logic [3:0][7:0] planes_reg, planes_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic            dropped_reg, dropped_next;
    logic            enabled_reg, enabled_next;
    logic [3:0][7:0] grp_planes;
    logic [2:0]      bitpos;
    pair_res_t       r0, r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= CTL_RESET;
            planes_reg <= '0;
            cnt_reg <= '0;
            dropped_reg <= 1'b0;
            enabled_reg <= 1'b0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            planes_reg <= planes_next;
            cnt_reg <= cnt_next;
            dropped_reg <= dropped_next;
            enabled_reg <= enabled_next;
        end
    end

    always_comb
    begin
        ctl_next = ctl_reg;
        planes_next = planes_reg;
        cnt_next = cnt_reg;
        dropped_next = dropped_reg;
        enabled_next = enabled_reg;
        push = 1'b0;
        grp = '{kind: GRP_BLACK, idx: '0, wr: '0};
        grp_planes = '0;
        bitpos = '0;
        r0 = '0;
        r1 = '0;
        if (accept)
        begin
            if (in_data.frame_start)
            begin
                ctl_next = CTL_RESET;
                planes_next = '0;
                cnt_next = '0;
                dropped_next = 1'b0;
                enabled_next = in_data.audio_enable_bit;
            end
            else if (in_data.line_start)
            begin
                planes_next = '0;
                cnt_next = '0;
                if (ctl_next.blank != 2'd0)
                begin
                    ctl_next.blank = ctl_next.blank - 1'b1;
                end
            end

            if (enabled_next && !dropped_next)
            begin
                // Samples arrive MSB first; plane p takes sample bit p.
                bitpos = 3'd7 - cnt_next;
                for (int p = 0; p < 4; p++)
                begin
                    planes_next[p][bitpos] = planes_next[p][bitpos] | in_data.sample[p];
                end
                cnt_next = cnt_next + 1'b1;
                if (cnt_next == 3'd0)
                begin
                    grp_planes = planes_next;
                    planes_next = '0;
                    push = 1'b1;
                    if (ctl_next.cmd_mode)
                    begin
                        r0 = run_pair(grp_planes[0], grp_planes[1], ctl_next, auto_detect);
                        r1 = run_pair(grp_planes[2], grp_planes[3], r0.ctl, auto_detect);
                        if (r0.reject)
                        begin
                            grp.kind = GRP_REJECT;
                            dropped_next = 1'b1;
                        end
                        else if (r1.reject)
                        begin
                            // The first pair's effects stand.
                            grp.kind = GRP_REJECT;
                            grp.wr[0] = r0.wr;
                            ctl_next = r0.ctl;
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            grp.kind = GRP_BLACK;
                            grp.wr[0] = r0.wr;
                            grp.wr[1] = r1.wr;
                            ctl_next = r1.ctl;
                        end
                    end
                    else if (ctl_next.blank != 2'd0)
                    begin
                        grp.kind = GRP_BLACK;
                    end
                    else
                    begin
                        grp.kind = GRP_PIXELS;
                        for (int k = 0; k < 4; k++)
                        begin
                            grp.idx[k] = grp_planes[k] & ctl_next.mask;
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== src/ppvd_queue.sv =====
// Short queue of group descriptors between the front and back ends.
// Depends on ppvd_pkg.
module ppvd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ppvd_pkg::grp_t push_data,
    input  logic           pop,
    output logic           head_valid,
    output ppvd_pkg::grp_t head_data,
    output logic           full
);
    import ppvd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    grp_t          slots [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head_data = slots[rptr_reg];
    assign full = (count_reg == FULL_COUNT);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == LAST_SLOT) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == LAST_SLOT) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

endmodule

// ===== src/ppvd_back.sv =====
// Back end: replays palette writes and palette reads of each group, one
// pixel slot per cycle while not stalled, into the output register.
// Holds the palette memory. Depends on ppvd_pkg.
module ppvd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ppvd_pkg::grp_t    head_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output ppvd_pkg::out_word_t out_data
);
    import ppvd_pkg::*;

    logic [7:0] pal_red   [PAL_DEPTH];
    logic [7:0] pal_green [PAL_DEPTH];
    logic [7:0] pal_blue  [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] written_reg;

    grp_t       cur_reg;
    logic       busy_reg;
    logic [1:0] k_reg;
    logic       outv_reg;
    logic       pix_reg, hit_reg, last_reg, rej_reg;
    logic [7:0] rd_red_reg, rd_green_reg, rd_blue_reg;

    logic              advance, issue, last_issue;
    wr_op_t            wop;
    logic              wen, rden;
    logic [PAL_AW-1:0] raddr;
    logic              fresh;
    logic [2:0]        we_c;
    logic [7:0]        wd_red, wd_green, wd_blue;

    assign advance = !outv_reg || !out_stall;
    assign issue = busy_reg && advance;
    assign last_issue = (cur_reg.kind == GRP_REJECT) || (k_reg == 2'd3);
    assign pop = head_valid && (!busy_reg || (issue && last_issue));

    always_comb
    begin
        wop = k_reg[0] ? cur_reg.wr[1] : cur_reg.wr[0];
        wen = issue && !k_reg[1] && wop.en;
        rden = issue && (cur_reg.kind == GRP_PIXELS);
        raddr = cur_reg.idx[k_reg];
        // The first write to an entry also zeroes its other two components.
        fresh = !written_reg[wop.addr];
        we_c[0] = wen && (fresh || wop.comp == COMP_RED);
        we_c[1] = wen && (fresh || wop.comp == COMP_GREEN);
        we_c[2] = wen && (fresh || wop.comp == COMP_BLUE);
        wd_red = (wop.comp == COMP_RED) ? wop.data : 8'd0;
        wd_green = (wop.comp == COMP_GREEN) ? wop.data : 8'd0;
        wd_blue = (wop.comp == COMP_BLUE) ? wop.data : 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (we_c[0])
        begin
            pal_red[wop.addr] <= wd_red;
        end
        if (we_c[1])
        begin
            pal_green[wop.addr] <= wd_green;
        end
        if (we_c[2])
        begin
            pal_blue[wop.addr] <= wd_blue;
        end
        if (rden)
        begin
            rd_red_reg <= pal_red[raddr];
            rd_green_reg <= pal_green[raddr];
            rd_blue_reg <= pal_blue[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_data;
        end
        if (issue)
        begin
            pix_reg <= (cur_reg.kind == GRP_PIXELS);
            hit_reg <= written_reg[raddr];
            last_reg <= last_issue;
            rej_reg <= (cur_reg.kind == GRP_REJECT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            busy_reg <= 1'b0;
            k_reg <= '0;
            outv_reg <= 1'b0;
        end
        else
        begin
            if (wen)
            begin
                written_reg[wop.addr] <= 1'b1;
            end
            if (pop)
            begin
                busy_reg <= 1'b1;
                k_reg <= '0;
            end
            else if (issue && last_issue)
            begin
                busy_reg <= 1'b0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (issue)
            begin
                outv_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                outv_reg <= 1'b0;
            end
        end
    end

    assign out_valid = outv_reg;
    assign out_data.red = (pix_reg && hit_reg) ? rd_red_reg : 8'd0;
    assign out_data.green = (pix_reg && hit_reg) ? rd_green_reg : 8'd0;
    assign out_data.blue = (pix_reg && hit_reg) ? rd_blue_reg : 8'd0;
    assign out_data.last_pixel = last_reg;
    assign out_data.frame_rejected = rej_reg;

endmodule

// ===== src/planar_palette_video_decoder_unit.sv =====
// Planar palette video decoder, top level. One sample is accepted per cycle
// while in_stall is low. A group's words leave one per cycle while out_stall
// is low (four, or one on rejection), set by the single palette read port.
// Reset clears control state and the palette written flags at once, so the
// palette reads as black with no clearing pass.
module planar_palette_video_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ppvd_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ppvd_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import ppvd_pkg::*;

    logic auto_detect_reg;
    logic q_full, q_push, q_pop, q_head_valid;
    grp_t q_push_data, q_head_data;

    assign cfg_ready = 1'b1;
    assign in_stall = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_detect_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            auto_detect_reg <= cfg_data;
        end
    end

    ppvd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_valid && !in_stall),
        .in_data     (in_data),
        .auto_detect (auto_detect_reg),
        .push        (q_push),
        .grp         (q_push_data)
    );

    ppvd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .full       (q_full)
    );

    ppvd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // A rejection word is always black and closes its group.
    a_reject_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_rejected |->
            out_data.last_pixel && out_data.red == 8'd0 &&
            out_data.green == 8'd0 && out_data.blue == 8'd0)
        else $error("rejection word carries color or misses last_pixel");

    // The front never pushes a group descriptor into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("group descriptor pushed into full queue");

    // The back end only pops a queue that holds a descriptor.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("group queue popped while empty");

endmodule

// ===== tb/sv/planar_palette_video_decoder_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for planar_palette_video_decoder_unit: drives IRGB sample words,
// predicts the decoded pixel words with its own palette and control state, and checks them.
// Depends on ppvd_pkg and the decoder top level only.
module planar_palette_video_decoder_unit_test;
    import ppvd_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int MAX_REPORTS = 40;
    localparam logic [7:0] CMD_END = 8'h08;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    planar_palette_video_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Decoder state as the testbench sees it.
    logic [7:0]  pal_copy [PAL_DEPTH][3];
    logic        cmd_mode;
    logic [1:0]  blank_left;
    logic [7:0]  idx_mask;
    logic [7:0]  color_ptr;
    logic [1:0]  comp_ptr;
    logic [31:0] plane_acc;
    logic [2:0]  grp_count;
    logic        frame_drop;
    logic        frame_en;
    logic        auto_det;

    out_word_t expected_pixels [$];
    int        mismatches;
    int        cycle_count;
    int        sent_samples;
    int        burst_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("planar_palette_video_decoder_unit test failed");
        $finish;
    end

    // Receiver back-pressure: picks one of four stall styles at random and holds it for a random run.
    initial
    begin
        int mode;
        int run;
        mode = 0;
        run = 0;
        forever
        begin
            @(posedge clk);
            if (run == 0)
            begin
                mode = $urandom_range(0, 3);
                run = $urandom_range(20, 120);
            end
            run--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ((cycle_count % 5) < 3);
                default: out_stall <= ($urandom_range(0, 99) < 70);
            endcase
        end
    end

    task automatic report_mismatch(input string field, input int expv, input int actv);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expv, actv);
        end
    endtask

    // A word is taken at the next rising edge if valid and not stalled at the falling edge.
    initial
    begin
        out_word_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: unexpected output word, expected none, actual %p",
                                 $time, out_data);
                    end
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_data.red !== want.red)
                        report_mismatch("red", int'(want.red), int'(out_data.red));
                    if (out_data.green !== want.green)
                        report_mismatch("green", int'(want.green), int'(out_data.green));
                    if (out_data.blue !== want.blue)
                        report_mismatch("blue", int'(want.blue), int'(out_data.blue));
                    if (out_data.last_pixel !== want.last_pixel)
                        report_mismatch("last_pixel", int'(want.last_pixel),
                                        int'(out_data.last_pixel));
                    if (out_data.frame_rejected !== want.frame_rejected)
                        report_mismatch("frame_rejected", int'(want.frame_rejected),
                                        int'(out_data.frame_rejected));
                end
            end
        end
    end

    function automatic void restart_frame_state();
        cmd_mode = 1'b1;
        blank_left = '0;
        idx_mask = MASK_RESET;
        color_ptr = '0;
        comp_ptr = COMP_RED;
        plane_acc = '0;
        grp_count = '0;
        frame_drop = 1'b0;
    endfunction

    function automatic void push_pixel(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic last,
                                       input logic rej);
        out_word_t w;
        w.red = r;
        w.green = g;
        w.blue = b;
        w.last_pixel = last;
        w.frame_rejected = rej;
        expected_pixels.push_back(w);
    endfunction

    // Applies one command/parameter pair; returns 1 when the frame is rejected.
    function automatic bit decode_pair(input logic [7:0] cmd, input logic [7:0] parm);
        logic [7:0] level;
        if (auto_det && cmd >= CMD_FOREIGN_MIN)
            return 1'b1;
        if (cmd[3])
        begin
            cmd_mode = 1'b0;
            blank_left = BLANK_LINES;
        end
        else if (cmd[2])
        begin
            case (op_t'(cmd[1:0]))
                OP_MASK: idx_mask = parm;
                OP_POINTER:
                begin
                    color_ptr = parm;
                    comp_ptr = COMP_RED;
                end
                OP_WRITE:
                begin
                    level = (parm << 2) | (parm & 8'h03);
                    pal_copy[color_ptr][comp_ptr] = level;
                    if (comp_ptr == COMP_BLUE)
                    begin
                        comp_ptr = COMP_RED;
                        color_ptr = color_ptr + 8'd1;
                    end
                    else
                    begin
                        comp_ptr = comp_ptr + 2'd1;
                    end
                end
                default: ;
            endcase
        end
        return 1'b0;
    endfunction

    function automatic void predict_sample(input in_word_t w);
        logic [2:0] bitpos;
        logic [7:0] planes [4];
        logic [7:0] c;
        if (w.frame_start)
        begin
            restart_frame_state();
            frame_en = w.audio_enable_bit;
        end
        else if (w.line_start)
        begin
            plane_acc = '0;
            grp_count = '0;
            if (blank_left != 0)
                blank_left = blank_left - 2'd1;
        end
        if (!frame_en || frame_drop)
            return;
        bitpos = 3'd7 - grp_count;
        if (w.sample[0]) plane_acc[bitpos] = 1'b1;
        if (w.sample[1]) plane_acc[8 + bitpos] = 1'b1;
        if (w.sample[2]) plane_acc[16 + bitpos] = 1'b1;
        if (w.sample[3]) plane_acc[24 + bitpos] = 1'b1;
        grp_count = grp_count + 3'd1;
        if (grp_count != 0)
            return;
        for (int k = 0; k < 4; k++)
            planes[k] = plane_acc[8 * k +: 8];
        plane_acc = '0;
        if (cmd_mode)
        begin
            // The second pair is skipped once the first one rejects the frame.
            if (decode_pair(planes[0], planes[1]) || decode_pair(planes[2], planes[3]))
            begin
                frame_drop = 1'b1;
                push_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
                return;
            end
            for (int k = 0; k < 4; k++)
                push_pixel(8'd0, 8'd0, 8'd0, k == 3, 1'b0);
        end
        else if (blank_left != 0)
        begin
            for (int k = 0; k < 4; k++)
                push_pixel(8'd0, 8'd0, 8'd0, k == 3, 1'b0);
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                c = planes[k] & idx_mask;
                push_pixel(pal_copy[c][COMP_RED], pal_copy[c][COMP_GREEN],
                           pal_copy[c][COMP_BLUE], k == 3, 1'b0);
            end
        end
    endfunction

    // Called just after a rising edge; returns just after the edge that took the word.
    task automatic send_word(input in_word_t w);
        int gap;
        bit taken;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        predict_sample(w);
        sent_samples++;
        burst_left--;
    endtask

    // Eight samples, MSB first, carrying the I, B, G and R plane bytes.
    task automatic send_group(input logic [7:0] i_byte, input logic [7:0] b_byte,
                              input logic [7:0] g_byte, input logic [7:0] r_byte,
                              input logic ls, input logic fs, input logic ae);
        in_word_t w;
        for (int k = 0; k < 8; k++)
        begin
            w.sample = {r_byte[7 - k], g_byte[7 - k], b_byte[7 - k], i_byte[7 - k]};
            w.line_start = (k == 0) ? ls : 1'b0;
            w.frame_start = (k == 0) ? fs : 1'b0;
            w.audio_enable_bit = (k == 0) ? ae : 1'($urandom_range(0, 1));
            send_word(w);
        end
    endtask

    task automatic send_loose_samples(input int n, input int ls_pct, input int fs_pct);
        in_word_t w;
        for (int k = 0; k < n; k++)
        begin
            w.sample = 4'($urandom_range(0, 15));
            w.line_start = ($urandom_range(0, 99) < ls_pct);
            w.frame_start = ($urandom_range(0, 99) < fs_pct);
            w.audio_enable_bit = 1'($urandom_range(0, 1));
            send_word(w);
        end
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_auto_detect(input logic value);
        bit taken;
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        auto_det = value;
        cfg_valid <= 1'b0;
    endtask

    // Palette indices cluster where the random palette loads land.
    function automatic logic [7:0] pick_index();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(0, 7));
            4, 5, 6: return 8'($urandom_range(8'hf8, 8'hff));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void make_pair(output logic [7:0] cmd, output logic [7:0] parm);
        logic [3:0] upper;
        int pick;
        pick = $urandom_range(0, 99);
        upper = 4'($urandom_range(0, 15));
        if (auto_det && $urandom_range(0, 9) != 0)
            upper[3:2] = 2'b00;
        parm = 8'($urandom_range(0, 255));
        if (pick < 40)
            cmd = {upper, 2'b01, OP_WRITE};
        else if (pick < 55)
        begin
            cmd = {upper, 2'b01, OP_POINTER};
            parm = pick_index();
        end
        else if (pick < 70)
        begin
            cmd = {upper, 2'b01, OP_MASK};
            if ($urandom_range(0, 1) != 0)
                parm = MASK_RESET;
        end
        else if (pick < 80)
            cmd = {upper, 2'b01, OP_NOP};
        else if (pick < 92)
            cmd = {upper, 2'b00, 2'($urandom_range(0, 3))};
        else
            cmd = 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_frame();
        logic [7:0] c1, p1, c2, p2;
        logic [7:0] end_cmd;
        logic ae;
        int ncmd;
        int nlines;
        ae = ($urandom_range(0, 9) != 0);
        ncmd = $urandom_range(1, 6);
        for (int g = 0; g < ncmd; g++)
        begin
            make_pair(c1, p1);
            make_pair(c2, p2);
            send_group(c1, p1, c2, p2, (g == 0) ? 1'($urandom_range(0, 1)) : 1'b0,
                       g == 0, ae);
        end
        // Most frames leave command mode; the end command may sit in either pair.
        if ($urandom_range(0, 9) != 0)
        begin
            end_cmd = {auto_det ? 2'b00 : 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       1'b1, 3'($urandom_range(0, 7))};
            make_pair(c1, p1);
            if ($urandom_range(0, 1) != 0)
                send_group(end_cmd, 8'($urandom_range(0, 255)), c1, p1, 1'b0, 1'b0, 1'b0);
            else
                send_group(c1, p1, end_cmd, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
        end
        nlines = $urandom_range(1, 5);
        for (int ln = 0; ln < nlines; ln++)
        begin
            for (int g = $urandom_range(1, 3); g > 0; g--)
            begin
                send_group(pick_index(), pick_index(), pick_index(), pick_index(),
                           g == 1 ? 1'b0 : 1'b0, 1'b0, 1'b0);
            end
            if ($urandom_range(0, 4) == 0)
                send_loose_samples($urandom_range(1, 7), 0, 0);
            if ($urandom_range(0, 9) == 0)
                send_loose_samples(8, 10, 3);
            // The next line begins with a line start on its first sample.
            send_group(pick_index(), pick_index(), pick_index(), pick_index(),
                       1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic test_disabled_frame();
        send_group(8'h04, 8'h00, 8'h06, 8'hff, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_palette_load_and_display();
        send_group(8'h04, 8'hff, 8'h06, 8'hff, 1'b1, 1'b1, 1'b1);
        // Blue completes entry 0xff and the color pointer wraps to 0.
        send_group(8'h06, 8'h00, 8'h06, 8'h15, 1'b0, 1'b0, 1'b0);
        send_group(8'h07, 8'ha5, 8'h30, 8'h5a, 1'b0, 1'b0, 1'b0);
        // The pair after the end command is still decoded.
        send_group(CMD_END, 8'h00, 8'h05, 8'hff, 1'b0, 1'b0, 1'b0);
        send_group(8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 1'b0);
        // A partial group is dropped at the next line start.
        send_loose_samples(1, 100, 0);
        send_loose_samples(2, 0, 0);
        send_group(8'hff, 8'h00, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_foreign_command();
        set_auto_detect(1'b1);
        // Rejected in the second pair after a mask load in the first.
        send_group(8'h05, 8'h01, CMD_FOREIGN_MIN, 8'h00, 1'b1, 1'b1, 1'b1);
        send_group(8'h05, 8'h02, 8'h05, 8'h03, 1'b0, 1'b0, 1'b0);
        send_group(8'hff, 8'h00, 8'h04, 8'h00, 1'b1, 1'b1, 1'b1);
        send_group(8'h3f, 8'h00, 8'h04, 8'h02, 1'b1, 1'b1, 1'b1);
        set_auto_detect(1'b0);
        send_group(8'hc4, 8'h02, 8'hc6, 8'haa, 1'b1, 1'b1, 1'b1);
        send_group(8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_group(8'h02, 8'h02, 8'hff, 8'h00, 1'b1, 1'b0, 1'b0);
        send_group(8'h02, 8'h02, 8'hff, 8'h00, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_random_frames(input logic setting, input int budget);
        int start;
        set_auto_detect(setting);
        start = sent_samples;
        while (sent_samples - start < budget)
            send_random_frame();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        mismatches = 0;
        sent_samples = 0;
        burst_left = 0;
        for (int e = 0; e < PAL_DEPTH; e++)
            for (int k = 0; k < 3; k++)
                pal_copy[e][k] = '0;
        restart_frame_state();
        frame_en = 1'b0;
        auto_det = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_frame();
        test_palette_load_and_display();
        test_foreign_command();
        test_random_frames(1'b0, 30);
        test_random_frames(1'b1, 30);
        test_random_frames(1'b0, 20);

        wait_until_drained();
        if (mismatches == 0)
            $display("planar_palette_video_decoder_unit test passed");
        else
            $display("planar_palette_video_decoder_unit test failed");
        $finish;
    end

endmodule
